[sv/csd_pkg.sv]
// csd_pkg: shared types, widths and codes for the cone signed distance unit
// depends on nothing; used by csd_cfg and cone_signed_distance_unit
package csd_pkg;

  localparam int unsigned SLOPE_W    = 24;
  localparam int unsigned SLOPE_FRAC = 16;
  localparam int unsigned HEIGHT_W   = 20;
  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned QX_W       = HEIGHT_W + 1 + SLOPE_W - SLOPE_FRAC;
  localparam int unsigned DEN_W      = 2 * QX_W;

  localparam logic [SLOPE_W-1:0]  SLOPE_RST  = 24'd65536;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 20'd2560;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd0;

  localparam logic [OUT_W-1:0] OUT_MAX = 24'h7fffff;
  localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOPE  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SGN_ZERO = 2'b00,
    SGN_POS  = 2'b01,
    SGN_NEG  = 2'b11
  } sgn_e;

  typedef struct packed {
    logic signed [QX_W-1:0]     qx;
    logic        [HEIGHT_W-1:0] h;
    logic        [DEN_W-1:0]    den;
    logic signed [OFFSET_W-1:0] off;
  } cone_t;

endpackage

[sv/csd_cfg.sv]
// csd_cfg: configuration registers and the cone terms derived from them
// depends on csd_pkg
module csd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [csd_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [csd_pkg::CFG_DATA_W-1:0] wdata_i,
  output csd_pkg::cone_t                 cone_o
);

  localparam int unsigned PW = csd_pkg::HEIGHT_W + csd_pkg::SLOPE_W + 1;

  logic signed [csd_pkg::SLOPE_W-1:0]  slope_q;
  logic        [csd_pkg::HEIGHT_W-1:0] height_q;
  logic signed [csd_pkg::OFFSET_W-1:0] offset_q;

  logic signed [PW-1:0]                   prod;
  logic signed [csd_pkg::QX_W-1:0]        qx_q;
  logic signed [csd_pkg::DEN_W-1:0]       qxsq;
  logic        [csd_pkg::DEN_W-1:0]       qxsq_q;
  logic        [2*csd_pkg::HEIGHT_W-1:0]  hsq_q;
  logic        [csd_pkg::DEN_W-1:0]       den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q  <= csd_pkg::SLOPE_RST;
      height_q <= csd_pkg::HEIGHT_RST;
      offset_q <= csd_pkg::OFFSET_RST;
    end else if (we_i) begin
      unique case (idx_i)
        csd_pkg::CFG_SLOPE:  slope_q  <= wdata_i[csd_pkg::SLOPE_W-1:0];
        csd_pkg::CFG_HEIGHT: height_q <= wdata_i[csd_pkg::HEIGHT_W-1:0];
        csd_pkg::CFG_OFFSET: offset_q <= wdata_i[csd_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign prod = $signed({1'b0, height_q}) * slope_q;
  assign qxsq = qx_q * qx_q;

  always_ff @(posedge clk_i) begin
    qx_q   <= prod[PW-1:csd_pkg::SLOPE_FRAC];
    qxsq_q <= $unsigned(qxsq);
    hsq_q  <= height_q * height_q;
    den_q  <= qxsq_q + csd_pkg::DEN_W'(hsq_q);
  end

  assign cone_o.qx  = qx_q;
  assign cone_o.h   = height_q;
  assign cone_o.den = den_q;
  assign cone_o.off = offset_q;

endmodule

[sv/csd_sqrt.sv]
// csd_sqrt: pipelined floor square root, one result bit per stage
// depends on nothing; sideband data travels alongside each operand
module csd_sqrt #(
  parameter int unsigned IW = 40,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [IW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [IW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned RW = IW / 2;

  logic          vld_q  [RW];
  logic [IW-1:0] rad_q  [RW];
  logic [RW:0]   rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic          vld_in;
    logic [IW-1:0] rad_in;
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic [RW+2:0] cur, tst, dif;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign cur = {rem_in, rad_in[IW-1 -: 2]};
    assign tst = {1'b0, root_in, 2'b01};
    assign dif = cur - tst;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i]  <= {rad_in[IW-3:0], 2'b00};
      side_q[i] <= side_in;
      if (cur >= tst) begin
        rem_q[i]  <= dif[RW:0];
        root_q[i] <= {root_in[RW-2:0], 1'b1};
      end else begin
        rem_q[i]  <= cur[RW:0];
        root_q[i] <= {root_in[RW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

[sv/csd_div.sv]
// csd_div: pipelined restoring fraction divider, one quotient bit per stage
// depends on nothing; expects num < den, sideband travels with the operands
module csd_div #(
  parameter int unsigned W     = 58,
  parameter int unsigned STEPS = 8,
  parameter int unsigned SW    = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [W-1:0]     num_i,
  input  logic [W-1:0]     den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [STEPS-1:0] quo_o,
  output logic [SW-1:0]    side_o
);

  logic             vld_q  [STEPS];
  logic [W-1:0]     rem_q  [STEPS];
  logic [W-1:0]     den_q  [STEPS];
  logic [STEPS-1:0] quo_q  [STEPS];
  logic [SW-1:0]    side_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic             vld_in;
    logic [W-1:0]     rem_in;
    logic [W-1:0]     den_in;
    logic [STEPS-1:0] quo_in;
    logic [SW-1:0]    side_in;
    logic [W:0]       sh, dif;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign den_in  = den_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign sh  = {rem_in, 1'b0};
    assign ge  = sh >= {1'b0, den_in};
    assign dif = sh - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? dif[W-1:0] : sh[W-1:0];
      den_q[i]  <= den_in;
      quo_q[i]  <= {quo_in[STEPS-2:0], ge};
      side_q[i] <= side_in;
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign quo_o   = quo_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

[sv/cone_signed_distance_unit.sv]
// cone_signed_distance_unit: capped cone signed distance, one voxel per cycle
// the pipeline runs through the radial root, the ratio dividers and the distance root,
//   plus 10 register stages of its own
// throughput one voxel every cycle, busy_o is always low; results cannot be held off
// asynchronous active-low reset clears all valid bits and loads the register defaults
// depends on csd_pkg, csd_cfg, csd_sqrt, csd_div
module cone_signed_distance_unit #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [COORD_BITS-1:0]   pos_x_i,
  input  logic signed [COORD_BITS-1:0]   pos_y_i,
  input  logic signed [COORD_BITS-1:0]   pos_z_i,
  input  logic                           cfg_we_i,
  input  logic [csd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           done_o,
  output logic signed [csd_pkg::OUT_W-1:0] distance_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned WXW  = CB + F;
  localparam int unsigned WYW  = CB + F;
  localparam int unsigned R2W  = 2 * CB;
  localparam int unsigned SQ1W = R2W + 2 * F;
  localparam int unsigned QXW  = csd_pkg::QX_W;
  localparam int unsigned HW   = csd_pkg::HEIGHT_W;
  localparam int unsigned DENW = csd_pkg::DEN_W;
  localparam int unsigned PXQ  = WXW + 1 + QXW;
  localparam int unsigned PYH  = WYW + HW + 1;
  localparam int unsigned PYQ  = WYW + QXW;
  localparam int unsigned PXH  = WXW + HW;
  localparam int unsigned NUMW = (PXQ > PYH ? PXQ : PYH) + 1;
  localparam int unsigned CRW  = (PYQ > PXH + 1 ? PYQ : PXH + 1) + 1;
  localparam int unsigned YHW  = (WYW > HW + 1 ? WYW : HW + 1) + 1;
  localparam int unsigned CW   = (NUMW > DENW ? NUMW : DENW) + 1;
  localparam int unsigned UW   = (WXW > QXW ? WXW : QXW);
  localparam int unsigned TW   = F + 1;
  localparam int unsigned QTW  = QXW + TW + 1;
  localparam int unsigned HTW  = HW + TW;
  localparam int unsigned A1   = (WXW + 1 > QXW + 2 ? WXW + 1 : QXW + 2);
  localparam int unsigned A2   = (WYW > HW + 2 ? WYW : HW + 2);
  localparam int unsigned AW   = (A1 > A2 ? A1 : A2) + 1;
  localparam int unsigned DW   = 2 * AW + 2;
  localparam int unsigned RW   = DW / 2;
  localparam int unsigned VW   = (RW > csd_pkg::OFFSET_W ? RW : csd_pkg::OFFSET_W) + 2;
  localparam int unsigned OW   = csd_pkg::OUT_W;
  localparam int unsigned TSW  = 2 + WXW + WYW + 2;

  localparam logic [TW-1:0] T_ONE = {1'b1, {F{1'b0}}};

  csd_pkg::cone_t cone;

  csd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cone_o  (cone)
  );

  assign busy_o = 1'b0;

  // input register
  logic                 v0_q;
  logic signed [CB-1:0] x0_q, y0_q, z0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= pos_x_i;
    y0_q <= pos_y_i;
    z0_q <= pos_z_i;
  end

  // radius squared
  logic                  v1_q;
  logic signed [R2W-1:0] xs, zs;
  logic        [R2W-1:0] r2_q;
  logic signed [WYW-1:0] wy1_q;

  assign xs = x0_q * x0_q;
  assign zs = z0_q * z0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q  <= $unsigned(xs) + $unsigned(zs);
    wy1_q <= $signed({y0_q, {F{1'b0}}});
  end

  logic           sq1_v;
  logic [WXW-1:0] sq1_wx;
  logic [WYW-1:0] sq1_wy;

  csd_sqrt #(.IW(SQ1W), .SW(WYW)) u_sqrt_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .rad_i   ({r2_q, {(2*F){1'b0}}}),
    .side_i  (wy1_q),
    .valid_o (sq1_v),
    .root_o  (sq1_wx),
    .side_o  (sq1_wy)
  );

  // cross products
  logic                  v2_q;
  logic signed [WYW-1:0] wy_in2;
  logic signed [PXQ-1:0] pxq_q;
  logic signed [PYH-1:0] pyh_q;
  logic signed [PYQ-1:0] pyq_q;
  logic        [PXH-1:0] pxh_q;
  logic        [WXW-1:0] wx2_q;
  logic signed [WYW-1:0] wy2_q;

  assign wy_in2 = $signed(sq1_wy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= sq1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    pxq_q <= $signed({1'b0, sq1_wx}) * cone.qx;
    pyh_q <= wy_in2 * $signed({1'b0, cone.h});
    pyq_q <= wy_in2 * cone.qx;
    pxh_q <= sq1_wx * cone.h;
    wx2_q <= sq1_wx;
    wy2_q <= wy_in2;
  end

  // projection numerator and side sign
  logic                   v3_q;
  logic signed [CRW-1:0]  side_cr;
  logic signed [YHW-1:0]  yh;
  csd_pkg::sgn_e          s1, s2, sgn_d;
  logic signed [NUMW-1:0] num3_q;
  csd_pkg::sgn_e          sgn3_q;
  logic        [WXW-1:0]  wx3_q;
  logic signed [WYW-1:0]  wy3_q;

  assign side_cr = CRW'(pyq_q) + CRW'(pxh_q);
  assign yh      = YHW'(wy2_q) + YHW'(cone.h);

  always_comb begin
    if (side_cr > 0)      s1 = csd_pkg::SGN_POS;
    else if (side_cr < 0) s1 = csd_pkg::SGN_NEG;
    else                  s1 = csd_pkg::SGN_ZERO;
    if (yh > 0)           s2 = csd_pkg::SGN_NEG;
    else if (yh < 0)      s2 = csd_pkg::SGN_POS;
    else                  s2 = csd_pkg::SGN_ZERO;
    if (cone.h == '0) begin
      sgn_d = csd_pkg::SGN_ZERO;
    end else if (s1 == csd_pkg::SGN_POS || s2 == csd_pkg::SGN_POS) begin
      sgn_d = csd_pkg::SGN_POS;
    end else if (s1 == csd_pkg::SGN_ZERO || s2 == csd_pkg::SGN_ZERO) begin
      sgn_d = csd_pkg::SGN_ZERO;
    end else begin
      sgn_d = csd_pkg::SGN_NEG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num3_q <= NUMW'(pxq_q) - NUMW'(pyh_q);
    sgn3_q <= sgn_d;
    wx3_q  <= wx2_q;
    wy3_q  <= wy2_q;
  end

  // ratio clamping ahead of the dividers
  logic                 v4_q;
  logic signed [CW-1:0] numc, denc;
  logic                 t_force_d, t_one_d, u_force_d, u_one_d;
  logic                 t_force_q, t_one_q, u_force_q, u_one_q;
  logic [DENW-1:0]      t_num_q;
  logic [UW-1:0]        u_num_q, u_den_q;
  logic [WXW-1:0]       wx4_q;
  logic [WYW-1:0]       wy4_q;
  logic [1:0]           sgn4_q;

  assign numc = CW'(num3_q);
  assign denc = CW'(cone.den);

  always_comb begin
    t_force_d = 1'b1;
    t_one_d   = 1'b0;
    if (cone.den == '0) begin
      t_one_d = (num3_q != '0);
    end else if (num3_q <= 0) begin
      t_one_d = 1'b0;
    end else if (numc >= denc) begin
      t_one_d = 1'b1;
    end else begin
      t_force_d = 1'b0;
    end
    u_force_d = 1'b1;
    u_one_d   = 1'b0;
    if (cone.qx == '0) begin
      u_one_d = (wx3_q != '0);
    end else if (cone.qx < 0) begin
      u_one_d = 1'b0;
    end else if (wx3_q == '0) begin
      u_one_d = 1'b0;
    end else if (UW'(wx3_q) >= UW'($unsigned(cone.qx))) begin
      u_one_d = 1'b1;
    end else begin
      u_force_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_force_q <= t_force_d;
    t_one_q   <= t_one_d;
    u_force_q <= u_force_d;
    u_one_q   <= u_one_d;
    t_num_q   <= DENW'($unsigned(num3_q));
    u_num_q   <= UW'(wx3_q);
    u_den_q   <= UW'($unsigned(cone.qx));
    wx4_q     <= wx3_q;
    wy4_q     <= wy3_q;
    sgn4_q    <= sgn3_q;
  end

  logic           dt_v, du_v;
  logic [F-1:0]   dt_quo, du_quo;
  logic [TSW-1:0] dt_side;
  logic [1:0]     du_side;

  csd_div #(.W(DENW), .STEPS(F), .SW(TSW)) u_div_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (t_num_q),
    .den_i   (cone.den),
    .side_i  ({t_force_q, t_one_q, wx4_q, wy4_q, sgn4_q}),
    .valid_o (dt_v),
    .quo_o   (dt_quo),
    .side_o  (dt_side)
  );

  csd_div #(.W(UW), .STEPS(F), .SW(2)) u_div_cap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (u_num_q),
    .den_i   (u_den_q),
    .side_i  ({u_force_q, u_one_q}),
    .valid_o (du_v),
    .quo_o   (du_quo),
    .side_o  (du_side)
  );

  // scaled side and cap points
  logic                  v5_q;
  logic [TW-1:0]         t, u;
  logic signed [QTW-1:0] qxt5_q, qxu5_q;
  logic        [HTW-1:0] ht5_q;
  logic        [WXW-1:0] wx5_q;
  logic signed [WYW-1:0] wy5_q;
  logic [1:0]            sgn5_q;

  assign t = dt_side[TSW-1] ? (dt_side[TSW-2] ? T_ONE : '0) : {1'b0, dt_quo};
  assign u = du_side[1] ? (du_side[0] ? T_ONE : '0) : {1'b0, du_quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= dt_v & du_v;
    end
  end

  always_ff @(posedge clk_i) begin
    qxt5_q <= cone.qx * $signed({1'b0, t});
    qxu5_q <= cone.qx * $signed({1'b0, u});
    ht5_q  <= cone.h * t;
    wx5_q  <= dt_side[WXW+WYW+1:WYW+2];
    wy5_q  <= $signed(dt_side[WYW+1:2]);
    sgn5_q <= dt_side[1:0];
  end

  // offsets from the two closest points
  logic                  v6_q;
  logic signed [QTW-1:0] qxt_sh, qxu_sh;
  logic signed [HTW:0]   nht, nht_sh;
  logic signed [AW-1:0]  ax, ay, bx, by;
  logic        [AW-1:0]  max6_q, may6_q, mbx6_q, mby6_q;
  logic [1:0]            sgn6_q;

  assign qxt_sh = qxt5_q >>> F;
  assign qxu_sh = qxu5_q >>> F;
  assign nht    = -$signed({1'b0, ht5_q});
  assign nht_sh = nht >>> F;
  assign ax     = AW'(wx5_q) - AW'(qxt_sh);
  assign ay     = AW'(wy5_q) - AW'(nht_sh);
  assign bx     = AW'(wx5_q) - AW'(qxu_sh);
  assign by     = AW'(wy5_q) + AW'(cone.h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    max6_q <= ax[AW-1] ? $unsigned(-ax) : $unsigned(ax);
    may6_q <= ay[AW-1] ? $unsigned(-ay) : $unsigned(ay);
    mbx6_q <= bx[AW-1] ? $unsigned(-bx) : $unsigned(bx);
    mby6_q <= by[AW-1] ? $unsigned(-by) : $unsigned(by);
    sgn6_q <= sgn5_q;
  end

  // squared lengths
  logic              v7_q;
  logic [2*AW-1:0]   sax7_q, say7_q, sbx7_q, sby7_q;
  logic [1:0]        sgn7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sax7_q <= max6_q * max6_q;
    say7_q <= may6_q * may6_q;
    sbx7_q <= mbx6_q * mbx6_q;
    sby7_q <= mby6_q * mby6_q;
    sgn7_q <= sgn6_q;
  end

  // nearer of the two
  logic          v8_q;
  logic [DW-1:0] da, db, d8_q;
  logic [1:0]    sgn8_q;

  assign da = DW'(sax7_q) + DW'(say7_q);
  assign db = DW'(sbx7_q) + DW'(sby7_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d8_q   <= (da < db) ? da : db;
    sgn8_q <= sgn7_q;
  end

  logic          sq2_v;
  logic [RW-1:0] sq2_root;
  logic [1:0]    sq2_sgn;

  csd_sqrt #(.IW(DW), .SW(2)) u_sqrt_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .rad_i   (d8_q),
    .side_i  (sgn8_q),
    .valid_o (sq2_v),
    .root_o  (sq2_root),
    .side_o  (sq2_sgn)
  );

  // sign, offset and saturation
  logic signed [VW-1:0] rs, offx, val;
  logic [VW-OW:0]       hi;
  logic [OW-1:0]        dist_d;
  logic                 done_q;
  logic [OW-1:0]        dist_q;

  assign rs   = $signed(VW'(sq2_root));
  assign offx = VW'(cone.off);

  always_comb begin
    case (csd_pkg::sgn_e'(sq2_sgn))
      csd_pkg::SGN_POS: val = rs - offx;
      csd_pkg::SGN_NEG: val = -rs - offx;
      default:          val = -offx;
    endcase
  end

  assign hi = val[VW-1:OW-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      dist_d = val[OW-1:0];
    end else if (val[VW-1]) begin
      dist_d = csd_pkg::OUT_MIN;
    end else begin
      dist_d = csd_pkg::OUT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sq2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign done_o     = done_q;
  assign distance_o = $signed(dist_q);

endmodule
